// ===== rtl/modbus_tcp_holding_register_slave_assert.svh =====
// Assertion macros shared by the Modbus TCP holding register slave.
// Concurrent checks in simulation; empty bodies when SYNTHESIS is defined.
`ifndef MODBUS_TCP_HOLDING_REGISTER_SLAVE_ASSERT_SVH
`define MODBUS_TCP_HOLDING_REGISTER_SLAVE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define MBHR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mbhr: same-cycle check failed");
// next-cycle implication
`define MBHR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mbhr: next-cycle check failed");
`else
`define MBHR_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define MBHR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/mbhr_pkg.sv =====
// Shared types and constants for the Modbus TCP holding register slave.
// No dependencies; imported by mbhr_ctrl, mbhr_dp and the top level.
`default_nettype none

package mbhr_pkg;

    // parameter defaults
    localparam int unsigned REGISTER_COUNT_DEF = 256;
    localparam int unsigned MAX_QUANTITY_DEF   = 16;
    localparam int unsigned FRAME_BYTES_DEF    = 64;

    // function codes
    localparam logic [7:0] FC_READ_HOLDING    = 8'd3;
    localparam logic [7:0] FC_WRITE_SINGLE    = 8'd6;
    localparam logic [7:0] FC_WRITE_MULTIPLE  = 8'd16;

    // frame sizes
    localparam int unsigned HDR_BYTES      = 13;  // bytes kept in flops; write data starts here
    localparam int unsigned MIN_FRAME      = 8;
    localparam int unsigned MIN_REQUEST    = 12;
    localparam int unsigned READ_PDU_BASE  = 3;   // length field of a read reply is 3 + 2N
    localparam logic [7:0]  WRITE_MULTI_LEN = 8'd6;

    // byte positions in the frame
    localparam logic [3:0] POS_LEN_HI     = 4'd4;
    localparam logic [3:0] POS_LEN_LO     = 4'd5;
    localparam logic [3:0] POS_UNIT       = 4'd6;
    localparam logic [3:0] POS_FUNC       = 4'd7;
    localparam logic [3:0] POS_ADDR_HI    = 4'd8;
    localparam logic [3:0] POS_ADDR_LO    = 4'd9;
    localparam logic [3:0] POS_QTY_HI     = 4'd10;
    localparam logic [3:0] POS_QTY_LO     = 4'd11;
    localparam logic [3:0] POS_BYTE_COUNT = 4'd12;
    localparam logic [3:0] POS_READ_COUNT = 4'd8;   // byte count in a read reply
    localparam logic [3:0] POS_READ_LAST  = 4'd8;   // last header byte of a read reply
    localparam logic [3:0] POS_ECHO_LAST  = 4'd11;  // last byte of a write reply

    typedef enum logic [1:0] {
        FN_READ,
        FN_WRITE_SINGLE,
        FN_WRITE_MULTIPLE
    } t_func;

    // controller -> datapath
    typedef struct packed {
        logic store_byte;
        logic len_clear;
        logic seq_reset;
        logic clr_write;
        logic wr_single;
        logic buf_rd_hi;
        logic buf_rd_lo;
        logic wr_multiple;
        logic reg_rd;
        logic load_hdr;
        logic load_hi;
        logic load_lo;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic  clr_done;
        logic  resp_ok;
        t_func kind;
        logic  hdr_last;
        logic  idx_last;
        logic  out_free;
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/modbus_tcp_holding_register_slave.sv =====
// Top level of the Modbus TCP holding register slave: APB register, controller, datapath.
// Depends on mbhr_pkg, mbhr_ctrl, mbhr_dp and the assertion macro header.
//
//  channel   | direction | handshake             | payload
//  ----------+-----------+-----------------------+---------------------------
//  rx frame  | in        | i_valid / o_ready     | i_rx_byte, i_frame_end
//  tx reply  | out       | o_valid / i_ready     | o_tx_byte, o_last
//  config    | in        | psel, penable, pwrite | paddr, pwdata -> prdata
//
// Flow: a frame byte is taken every cycle while receiving. A frame end leads to decode.
//   Write multiple takes each register in steps: two frame buffer reads through its
//   registered port, then the register write. Replies leave one header byte per cycle
//   while the output is not stalled, then per register: memory read, high, low byte.
// Reset: synchronous, active low; afterwards a clearing pass writes zero to every
//   holding register, with o_ready low.
// Stalls: o_ready is low from frame end until the last reply byte sits in the output
//   register; a stalled output holds the sequencer. Config writes are taken any time.
`default_nettype none
`include "modbus_tcp_holding_register_slave_assert.svh"

module modbus_tcp_holding_register_slave #(
    parameter int unsigned REGISTER_COUNT = mbhr_pkg::REGISTER_COUNT_DEF,
    parameter int unsigned MAX_QUANTITY   = mbhr_pkg::MAX_QUANTITY_DEF,
    parameter int unsigned FRAME_BYTES    = mbhr_pkg::FRAME_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // frame bytes in
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_frame_end,
    // reply bytes out
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_tx_byte,
    output logic        o_last
);
    import mbhr_pkg::*;

    // register map: paddr[2] selects the register, low bits are byte lanes
    localparam logic REG_DEVICE_ID = 1'b0;

    logic [7:0] r_device_id;
    logic       w_cfg_wr;
    t_cmd       w_cmd;
    t_sts       w_sts;

    // ------------------------------------------------------------------
    // configuration: unit id this slave answers to, reset to 1
    // ------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_id <= 8'd1;
        end else if (w_cfg_wr && (paddr[2] == REG_DEVICE_ID)) begin
            r_device_id <= pwdata[7:0];
        end
    end

    assign prdata = (paddr[2] == REG_DEVICE_ID) ? {24'd0, r_device_id} : 32'd0;

    // ------------------------------------------------------------------
    // controller: sequences the clear pass, receive, decode, write loop and reply
    // ------------------------------------------------------------------
    mbhr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_frame_end (i_frame_end),
        .o_ready     (o_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // ------------------------------------------------------------------
    // datapath: frame storage, request checks, register file, output reg
    // ------------------------------------------------------------------
    mbhr_dp #(
        .REGISTER_COUNT (REGISTER_COUNT),
        .MAX_QUANTITY   (MAX_QUANTITY),
        .FRAME_BYTES    (FRAME_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_device_id (r_device_id),
        .i_rx_byte   (i_rx_byte),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_ready     (i_ready),
        .o_valid     (o_valid),
        .o_tx_byte   (o_tx_byte),
        .o_last      (o_last)
    );

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    // a reply byte that is not the last means the reply is still going out
    `MBHR_ASSERT_IMPLY(a_no_rx_mid_reply, i_clk, i_rst_n, o_valid && !o_last, !o_ready)
    // the frame end transfer always leads to the decode state
    `MBHR_ASSERT_NEXT(a_decode_after_end, i_clk, i_rst_n,
        i_valid && o_ready && i_frame_end, !o_ready)
    // only one writer of the register memory at a time
    `MBHR_ASSERT_IMPLY(a_one_reg_writer, i_clk, i_rst_n, 1'b1,
        $onehot0({w_cmd.clr_write, w_cmd.wr_single, w_cmd.wr_multiple}))

endmodule

`default_nettype wire

// ===== rtl/mbhr_dp.sv =====
// Datapath: frame buffer, header flops, holding register memory, output register.
// Depends on mbhr_pkg; driven by mbhr_ctrl.
`default_nettype none

module mbhr_dp #(
    parameter int unsigned REGISTER_COUNT = mbhr_pkg::REGISTER_COUNT_DEF,
    parameter int unsigned MAX_QUANTITY   = mbhr_pkg::MAX_QUANTITY_DEF,
    parameter int unsigned FRAME_BYTES    = mbhr_pkg::FRAME_BYTES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [7:0]     i_device_id,
    input  logic [7:0]     i_rx_byte,
    input  mbhr_pkg::t_cmd i_cmd,
    output mbhr_pkg::t_sts o_sts,
    input  logic           i_ready,
    output logic           o_valid,
    output logic [7:0]     o_tx_byte,
    output logic           o_last
);
    import mbhr_pkg::*;

    localparam int unsigned AW = $clog2(REGISTER_COUNT);
    localparam int unsigned BW = $clog2(FRAME_BYTES);
    localparam int unsigned CW = $clog2(FRAME_BYTES + 1);
    localparam int unsigned QW = $clog2(MAX_QUANTITY + 1);
    localparam logic [CW-1:0] LEN_FULL  = CW'(FRAME_BYTES);
    localparam logic [16:0]   REG_LIMIT = 17'(REGISTER_COUNT);
    localparam logic [AW-1:0] CLR_LAST  = AW'(REGISTER_COUNT - 1);
    localparam logic [15:0]   QTY_MAX   = 16'(MAX_QUANTITY);

    logic [7:0]    r_frame [FRAME_BYTES];
    logic [7:0]    r_buf_q;
    logic [15:0]   r_regs [REGISTER_COUNT];
    logic [15:0]   r_reg_q;
    logic [7:0]    r_hdr [HDR_BYTES];
    logic [7:0]    r_hi;
    logic [CW-1:0] r_len;
    logic [AW-1:0] r_clr_idx;
    logic [QW-1:0] r_idx;
    logic [3:0]    r_k;
    logic          r_out_valid;
    logic [7:0]    r_tx_byte;
    logic          r_last;

    logic [15:0]   w_addr;
    logic [15:0]   w_qty;
    logic [QW-1:0] w_qty_n;
    logic [AW-1:0] w_reg_addr;
    logic [BW-1:0] w_pair_base;
    logic [BW-1:0] w_buf_addr;
    logic [16:0]   w_span;
    logic [17:0]   w_need;
    logic [15:0]   w_resp_len;
    logic          w_is_read, w_is_single, w_is_multi;
    logic          w_ok_common, w_ok_single, w_ok_block, w_ok_multi;
    t_func         w_kind;
    logic [7:0]    w_hdr_byte;
    logic          w_hdr_last;
    logic          w_idx_last;
    logic          w_reg_we;
    logic [AW-1:0] w_reg_wa;
    logic [15:0]   w_reg_wd;

    assign w_addr      = {r_hdr[POS_ADDR_HI], r_hdr[POS_ADDR_LO]};
    assign w_qty       = {r_hdr[POS_QTY_HI], r_hdr[POS_QTY_LO]};
    assign w_qty_n     = w_qty[QW-1:0];
    assign w_reg_addr  = w_addr[AW-1:0] + AW'(r_idx);
    assign w_pair_base = BW'(HDR_BYTES) + BW'({r_idx, 1'b0});
    assign w_buf_addr  = i_cmd.buf_rd_lo ? w_pair_base + BW'(1) : w_pair_base;

    // request checks
    assign w_is_read   = r_hdr[POS_FUNC] == FC_READ_HOLDING;
    assign w_is_single = r_hdr[POS_FUNC] == FC_WRITE_SINGLE;
    assign w_is_multi  = r_hdr[POS_FUNC] == FC_WRITE_MULTIPLE;
    assign w_span      = {1'b0, w_addr} + {1'b0, w_qty};
    assign w_need      = 18'(HDR_BYTES) + 18'({w_qty, 1'b0});
    assign w_resp_len  = 16'(READ_PDU_BASE) + {w_qty[14:0], 1'b0};

    assign w_ok_common = (r_len >= CW'(MIN_FRAME)) && (r_hdr[POS_UNIT] == i_device_id)
                         && (w_is_read || w_is_single || w_is_multi)
                         && (r_len >= CW'(MIN_REQUEST));
    assign w_ok_single = {1'b0, w_addr} < REG_LIMIT;
    assign w_ok_block  = (w_qty != 16'd0) && (w_qty <= QTY_MAX) && (w_span <= REG_LIMIT);
    assign w_ok_multi  = (18'(r_len) >= w_need)
                         && (r_hdr[POS_BYTE_COUNT] == {w_qty[6:0], 1'b0});

    always_comb begin
        if (w_is_single) begin
            w_kind = FN_WRITE_SINGLE;
        end else if (w_is_multi) begin
            w_kind = FN_WRITE_MULTIPLE;
        end else begin
            w_kind = FN_READ;
        end
    end

    // reply header bytes: echo with a few substituted fields
    always_comb begin
        w_hdr_byte = r_hdr[r_k];
        case (w_kind)
            FN_READ: begin
                if (r_k == POS_LEN_HI) begin
                    w_hdr_byte = w_resp_len[15:8];
                end else if (r_k == POS_LEN_LO) begin
                    w_hdr_byte = w_resp_len[7:0];
                end else if (r_k == POS_READ_COUNT) begin
                    w_hdr_byte = {w_qty[6:0], 1'b0};
                end
            end
            FN_WRITE_MULTIPLE: begin
                if (r_k == POS_LEN_HI) begin
                    w_hdr_byte = 8'd0;
                end else if (r_k == POS_LEN_LO) begin
                    w_hdr_byte = WRITE_MULTI_LEN;
                end
            end
            default: ;
        endcase
    end

    assign w_hdr_last = (w_kind == FN_READ) ? (r_k == POS_READ_LAST) : (r_k == POS_ECHO_LAST);
    assign w_idx_last = r_idx == (w_qty_n - QW'(1));

    always_comb begin
        w_reg_we = 1'b1;
        w_reg_wa = w_reg_addr;
        w_reg_wd = {r_hi, r_buf_q};
        if (i_cmd.clr_write) begin
            w_reg_wa = r_clr_idx;
            w_reg_wd = '0;
        end else if (i_cmd.wr_single) begin
            w_reg_wa = w_addr[AW-1:0];
            w_reg_wd = w_qty;
        end else if (!i_cmd.wr_multiple) begin
            w_reg_we = 1'b0;
        end
    end

    always_comb begin
        o_sts.clr_done = r_clr_idx == CLR_LAST;
        o_sts.resp_ok  = w_ok_common && (w_is_single ? w_ok_single
                                        : (w_ok_block && (w_is_read || w_ok_multi)));
        o_sts.kind     = w_kind;
        o_sts.hdr_last = w_hdr_last;
        o_sts.idx_last = w_idx_last;
        o_sts.out_free = !r_out_valid || i_ready;
    end

    // memories and payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_byte && (r_len < LEN_FULL)) begin
            r_frame[r_len[BW-1:0]] <= i_rx_byte;
        end
        if (i_cmd.buf_rd_hi || i_cmd.buf_rd_lo) begin
            r_buf_q <= r_frame[w_buf_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_reg_we) begin
            r_regs[w_reg_wa] <= w_reg_wd;
        end
        if (i_cmd.reg_rd) begin
            r_reg_q <= r_regs[w_reg_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store_byte && (r_len < CW'(HDR_BYTES))) begin
            r_hdr[r_len[3:0]] <= i_rx_byte;
        end
        if (i_cmd.buf_rd_lo) begin
            r_hi <= r_buf_q;
        end
        if (i_cmd.load_hdr) begin
            r_tx_byte <= w_hdr_byte;
            r_last    <= w_hdr_last && (w_kind != FN_READ);
        end else if (i_cmd.load_hi) begin
            r_tx_byte <= r_reg_q[15:8];
            r_last    <= 1'b0;
        end else if (i_cmd.load_lo) begin
            r_tx_byte <= r_reg_q[7:0];
            r_last    <= w_idx_last;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_clr_idx   <= '0;
            r_idx       <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.len_clear) begin
                r_len <= '0;
            end else if (i_cmd.store_byte && (r_len < LEN_FULL)) begin
                r_len <= r_len + CW'(1);
            end
            if (i_cmd.clr_write && (r_clr_idx != CLR_LAST)) begin
                r_clr_idx <= r_clr_idx + AW'(1);
            end
            if (i_cmd.seq_reset) begin
                r_idx <= '0;
                r_k   <= '0;
            end else begin
                if (i_cmd.load_hdr) begin
                    r_k <= r_k + 4'd1;
                end
                if (i_cmd.wr_multiple || i_cmd.load_lo) begin
                    r_idx <= r_idx + QW'(1);
                end
            end
            if (i_cmd.load_hdr || i_cmd.load_hi || i_cmd.load_lo) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid   = r_out_valid;
    assign o_tx_byte = r_tx_byte;
    assign o_last    = r_last;

endmodule

`default_nettype wire

// ===== rtl/mbhr_ctrl.sv =====
// Controller FSM: clear pass, receive, decode, register write loop, reply emission.
// Depends on mbhr_pkg; drives mbhr_dp through t_cmd, watches t_sts.
`default_nettype none

module mbhr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_frame_end,
    output logic           o_ready,
    input  mbhr_pkg::t_sts i_sts,
    output mbhr_pkg::t_cmd o_cmd
);
    import mbhr_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_RECV,
        S_DECODE,
        S_WR_HI,
        S_WR_LO,
        S_WR_COMMIT,
        S_HDR,
        S_RD_ISSUE,
        S_DATA_HI,
        S_DATA_LO
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_write = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_RECV;
                end
            end
            S_RECV: begin
                o_cmd.store_byte = i_valid;
                if (i_valid && i_frame_end) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.len_clear = 1'b1;
                o_cmd.seq_reset = 1'b1;
                if (!i_sts.resp_ok) begin
                    n_state = S_RECV;
                end else begin
                    unique case (i_sts.kind)
                        FN_WRITE_SINGLE: begin
                            o_cmd.wr_single = 1'b1;
                            n_state = S_HDR;
                        end
                        FN_WRITE_MULTIPLE: n_state = S_WR_HI;
                        default:           n_state = S_HDR;
                    endcase
                end
            end
            S_WR_HI: begin
                o_cmd.buf_rd_hi = 1'b1;
                n_state = S_WR_LO;
            end
            S_WR_LO: begin
                o_cmd.buf_rd_lo = 1'b1;
                n_state = S_WR_COMMIT;
            end
            S_WR_COMMIT: begin
                o_cmd.wr_multiple = 1'b1;
                n_state = i_sts.idx_last ? S_HDR : S_WR_HI;
            end
            S_HDR: begin
                if (i_sts.out_free) begin
                    o_cmd.load_hdr = 1'b1;
                    if (i_sts.hdr_last) begin
                        n_state = (i_sts.kind == FN_READ) ? S_RD_ISSUE : S_RECV;
                    end
                end
            end
            S_RD_ISSUE: begin
                o_cmd.reg_rd = 1'b1;
                n_state = S_DATA_HI;
            end
            S_DATA_HI: begin
                if (i_sts.out_free) begin
                    o_cmd.load_hi = 1'b1;
                    n_state = S_DATA_LO;
                end
            end
            S_DATA_LO: begin
                if (i_sts.out_free) begin
                    o_cmd.load_lo = 1'b1;
                    n_state = i_sts.idx_last ? S_RECV : S_RD_ISSUE;
                end
            end
            default: n_state = S_RECV;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = r_state == S_RECV;

endmodule

`default_nettype wire
